// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mrs_pkg.sv
// Types, codes and constants of the motor run supervisor.
package mrs_pkg;

   localparam int DIV_W = 66;
   localparam int CNT_W = 7;
   localparam int CSR_IDX_W = 3;

   localparam logic [19:0] MG_PER_KG = 20'd1000000;
   localparam logic [31:0] MS_PER_S = 32'd1000;
   localparam logic [31:0] HALF_K = 32'd500;
   localparam logic [31:0] MIN_RUN_MS = 32'd100;
   localparam logic [31:0] MIN_GRAMS = 32'd10;
   localparam logic [31:0] MAX_GRAMS = 32'd65535;
   localparam logic [31:0] BATT_GRACE_MS = 32'd1000;

   localparam logic [2:0] MODE_TICK = 3'd0;
   localparam logic [2:0] MODE_MASS = 3'd1;
   localparam logic [2:0] MODE_TIMED = 3'd2;
   localparam logic [2:0] MODE_STOP = 3'd3;
   localparam logic [2:0] MODE_CLEAR = 3'd4;

   localparam logic [2:0] RES_OK = 3'd0;
   localparam logic [2:0] RES_BUSY = 3'd1;
   localparam logic [2:0] RES_FAULT = 3'd2;
   localparam logic [2:0] RES_SENSOR = 3'd3;
   localparam logic [2:0] RES_UNCAL = 3'd4;
   localparam logic [2:0] RES_RANGE = 3'd5;
   localparam logic [2:0] RES_BATTERY = 3'd6;
   localparam logic [2:0] RES_NOT_RUN = 3'd7;

   localparam logic [1:0] FIN_NONE = 2'd0;
   localparam logic [1:0] FIN_SUCCESS = 2'd1;
   localparam logic [1:0] FIN_USER = 2'd2;
   localparam logic [1:0] FIN_FAULT = 2'd3;

   localparam logic [2:0] FLT_NONE = 3'd0;
   localparam logic [2:0] FLT_OVERCURRENT = 3'd1;
   localparam logic [2:0] FLT_SENSOR = 3'd2;
   localparam logic [2:0] FLT_BATTERY = 3'd3;
   localparam logic [2:0] FLT_MAXRUN = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_FEED_RATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RUN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUR_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CUR_DELAY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CRIT_BATT = 3'd4;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PREP = 6'b000010,
      ST_EVAL = 6'b000100,
      ST_FMUL = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      DT_DUR,
      DT_MG,
      DT_G,
      DT_SEC
   } div_tag_type;

   typedef struct packed {
      logic [2:0]  command_result;
      logic [1:0]  finish_kind;
      logic [15:0] estimated_grams;
      logic [15:0] duration_seconds;
      logic [15:0] planned_grams;
   } rsp_type;

   function automatic logic [15:0] sat16(input logic [DIV_W-1:0] v);
      return (|v[DIV_W-1:16]) ? 16'hFFFF : v[15:0];
   endfunction

endpackage

// File: rtl/mrs_channels.sv
// Channel interfaces: request, response and register write.
interface mrs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [31:0] now_ms;
   logic [15:0] current_ma;
   logic [15:0] battery_mv;
   logic        battery_valid;
   logic        sensor_ok;
   logic [31:0] amount_or_duration;
   modport source (output valid, mode, now_ms, current_ma, battery_mv, battery_valid,
                   sensor_ok, amount_or_duration, input ready);
   modport sink (input valid, mode, now_ms, current_ma, battery_mv, battery_valid,
                 sensor_ok, amount_or_duration, output ready);
endinterface

interface mrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command_result;
   logic        motor_on;
   logic [1:0]  finish_kind;
   logic [2:0]  fault_code;
   logic [15:0] estimated_grams;
   logic [15:0] duration_seconds;
   logic [15:0] peak_current_ma;
   logic [15:0] trip_current_ma;
   logic [15:0] planned_grams;
   modport source (output valid, command_result, motor_on, finish_kind, fault_code,
                   estimated_grams, duration_seconds, peak_current_ma, trip_current_ma,
                   planned_grams, input ready);
   modport sink (input valid, command_result, motor_on, finish_kind, fault_code,
                 estimated_grams, duration_seconds, peak_current_ma, trip_current_ma,
                 planned_grams, output ready);
endinterface

interface mrs_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/mrs_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module mrs_sdiv
   import mrs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [DIV_W-1:0] num,
   input  logic [31:0]      den,
   output logic             done,
   output logic [DIV_W-1:0] quo
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      den_ff, den_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [32:0]      shifted;
   logic [32:0]      diff;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff = shifted - {1'b0, den_ff};
   assign ge = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         den_in = den;
         quo_in = num;
      end else if (busy_ff) begin
         rem_in = ge ? diff[31:0] : shifted[31:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo = quo_ff;

endmodule

// File: rtl/motor_run_supervisor.sv
// Motor run supervisor top level.
//
// req_bus carries one command per transaction (tick, start by mass, timed
// start, user stop, fault reset); rsp_bus returns exactly one result per
// request, in order. csr_bus writes the five setup registers and is always
// ready; write it only while no request is outstanding.
// One request is processed at a time. A start by mass with an in-range
// amount and a nonzero feed rate first runs one divider pass (load, 66
// quotient bits, handoff) for the run duration. A finish runs the seconds
// division and, with a nonzero feed rate, first a multiply step and two
// more divider passes for the estimated grams.
// The divider produces one quotient bit per cycle.
// A finished response sits in the output register; the next request is
// accepted meanwhile and its response waits until the held one is taken.
// Synchronous reset clears the run state, the fault latch and the setup
// registers to their defaults; no response is pending after reset.
module motor_run_supervisor
   import mrs_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   mrs_req_if.sink   req_bus,
   mrs_rsp_if.source rsp_bus,
   mrs_csr_if.sink   csr_bus
);

   state_type   state_ff, state_in;
   div_tag_type tag_ff, tag_in;

   logic [31:0] feed_rate_ff, max_run_ff, cur_delay_ff;
   logic [15:0] cur_limit_ff, crit_batt_ff;

   logic [2:0]  mode_ff;
   logic [31:0] now_ff, arg_ff;
   logic [15:0] cur_ff, batt_mv_ff;
   logic        batt_valid_ff, sensor_ok_ff;

   logic        running_ff, running_in;
   logic [2:0]  fault_ff, fault_in;
   logic [31:0] start_time_ff, start_time_in;
   logic [31:0] target_ff, target_in;
   logic [15:0] req_grams_ff, req_grams_in;
   logic [15:0] peak_ff, peak_in;
   logic [15:0] trip_ff, trip_in;
   logic        over_ff, over_in;
   logic [31:0] over_start_ff, over_start_in;

   logic [31:0] fin_dur_ff;
   rsp_type     res_ff, res_in;
   rsp_type     out_ff;
   logic        rsp_valid_ff;
   logic        motor_out_ff;
   logic [2:0]  fault_out_ff;
   logic [15:0] peak_out_ff, trip_out_ff;

   logic             div_go_ff;
   logic [DIV_W-1:0] div_num_ff;
   logic [31:0]      div_den_ff;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;

   logic [35:0] mass_prod;
   logic [63:0] mg_prod;
   logic [31:0] elapsed, over_elapsed;
   logic        batt_low, dur_bad, mass_ok, fin_done;
   logic        try_start;
   logic [31:0] try_dur;
   logic [15:0] try_grams;
   logic [2:0]  fin_fault;

   mrs_sdiv u_sdiv (
      .clock (clock),
      .reset (reset),
      .go    (div_go_ff),
      .num   (div_num_ff),
      .den   (div_den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == ST_IDLE);

   assign mass_prod = arg_ff[15:0] * MG_PER_KG;
   assign mg_prod = 64'(feed_rate_ff) * 64'(fin_dur_ff);
   assign elapsed = now_ff - start_time_ff;
   assign over_elapsed = now_ff - over_start_ff;
   assign batt_low = batt_valid_ff && (crit_batt_ff != 16'd0) && (batt_mv_ff < crit_batt_ff);
   assign dur_bad = (div_quo == '0) || (|div_quo[DIV_W-1:32]) || (div_quo[31:0] > max_run_ff);
   assign mass_ok = (feed_rate_ff != 32'd0) && (arg_ff >= MIN_GRAMS) && (arg_ff <= MAX_GRAMS);

   always_comb begin
      running_in = running_ff;
      fault_in = fault_ff;
      start_time_in = start_time_ff;
      target_in = target_ff;
      req_grams_in = req_grams_ff;
      peak_in = peak_ff;
      trip_in = trip_ff;
      over_in = over_ff;
      over_start_in = over_start_ff;
      res_in = '0;
      try_start = 1'b0;
      try_dur = arg_ff;
      try_grams = 16'd0;
      fin_fault = FLT_NONE;
      fin_done = 1'b0;
      unique case (mode_ff)
         MODE_MASS: begin
            if (feed_rate_ff == 32'd0) begin
               res_in.command_result = RES_UNCAL;
            end else if (!mass_ok || dur_bad) begin
               res_in.command_result = RES_RANGE;
            end else begin
               try_start = 1'b1;
               try_dur = div_quo[31:0];
               try_grams = arg_ff[15:0];
            end
         end
         MODE_TIMED: begin
            try_start = 1'b1;
         end
         MODE_STOP: begin
            if (!running_ff) begin
               res_in.command_result = RES_NOT_RUN;
            end else begin
               res_in.finish_kind = FIN_USER;
            end
         end
         MODE_CLEAR: begin
            if (running_ff) begin
               res_in.command_result = RES_BUSY;
            end else if (!sensor_ok_ff) begin
               fault_in = FLT_SENSOR;
               res_in.command_result = RES_SENSOR;
            end else if (batt_low) begin
               res_in.command_result = RES_BATTERY;
            end else begin
               fault_in = FLT_NONE;
            end
         end
         MODE_TICK: begin
            if (running_ff) begin
               if (cur_ff > peak_ff) peak_in = cur_ff;
               if (cur_ff >= cur_limit_ff) begin
                  if (!over_ff) begin
                     over_in = 1'b1;
                     over_start_in = now_ff;
                  end else if (over_elapsed >= cur_delay_ff) begin
                     trip_in = cur_ff;
                     res_in.finish_kind = FIN_FAULT;
                     fin_fault = FLT_OVERCURRENT;
                     fin_done = 1'b1;
                  end
               end else begin
                  over_in = 1'b0;
               end
               if (!fin_done) begin
                  if (elapsed >= max_run_ff) begin
                     res_in.finish_kind = FIN_FAULT;
                     fin_fault = FLT_MAXRUN;
                  end else if (batt_low && (elapsed > BATT_GRACE_MS)) begin
                     res_in.finish_kind = FIN_FAULT;
                     fin_fault = FLT_BATTERY;
                  end else if (elapsed >= target_ff) begin
                     res_in.finish_kind = FIN_SUCCESS;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      if (try_start) begin
         if (running_ff) begin
            res_in.command_result = RES_BUSY;
         end else if (fault_ff != FLT_NONE) begin
            res_in.command_result = RES_FAULT;
         end else if ((try_dur < MIN_RUN_MS) || (try_dur > max_run_ff)) begin
            res_in.command_result = RES_RANGE;
         end else if (!sensor_ok_ff) begin
            fault_in = FLT_SENSOR;
            res_in.command_result = RES_SENSOR;
         end else if (batt_low) begin
            fault_in = FLT_BATTERY;
            res_in.command_result = RES_BATTERY;
         end else begin
            target_in = try_dur;
            req_grams_in = try_grams;
            peak_in = 16'd0;
            trip_in = 16'd0;
            over_in = 1'b0;
            start_time_in = now_ff;
            running_in = 1'b1;
         end
      end
      if (res_in.finish_kind != FIN_NONE) begin
         fault_in = fin_fault;
         running_in = 1'b0;
         req_grams_in = 16'd0;
         res_in.planned_grams = req_grams_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      tag_in = tag_ff;
      unique case (state_ff)
         ST_IDLE: if (req_bus.valid) state_in = ST_PREP;
         ST_PREP: begin
            if ((mode_ff == MODE_MASS) && mass_ok) begin
               state_in = ST_DIV;
               tag_in = DT_DUR;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (res_in.finish_kind == FIN_NONE) begin
               state_in = ST_OUT;
            end else if (feed_rate_ff != 32'd0) begin
               state_in = ST_FMUL;
            end else begin
               state_in = ST_DIV;
               tag_in = DT_SEC;
            end
         end
         ST_FMUL: begin
            state_in = ST_DIV;
            tag_in = DT_MG;
         end
         ST_DIV: begin
            if (div_done) begin
               case (tag_ff)
                  DT_DUR: state_in = ST_EVAL;
                  DT_MG: tag_in = DT_G;
                  DT_G: tag_in = DT_SEC;
                  default: state_in = ST_OUT;
               endcase
            end
         end
         ST_OUT: if (!rsp_valid_ff || rsp_bus.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tag_ff <= DT_DUR;
         feed_rate_ff <= 32'd0;
         max_run_ff <= 32'd30000;
         cur_limit_ff <= 16'd2000;
         cur_delay_ff <= 32'd100;
         crit_batt_ff <= 16'd0;
         running_ff <= 1'b0;
         fault_ff <= FLT_NONE;
         start_time_ff <= 32'd0;
         target_ff <= 32'd0;
         req_grams_ff <= 16'd0;
         peak_ff <= 16'd0;
         trip_ff <= 16'd0;
         over_ff <= 1'b0;
         over_start_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tag_ff <= tag_in;
         div_go_ff <= 1'b0;
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               CSR_FEED_RATE: feed_rate_ff <= csr_bus.data;
               CSR_MAX_RUN: max_run_ff <= csr_bus.data;
               CSR_CUR_LIMIT: cur_limit_ff <= csr_bus.data[15:0];
               CSR_CUR_DELAY: cur_delay_ff <= csr_bus.data;
               CSR_CRIT_BATT: crit_batt_ff <= csr_bus.data[15:0];
               default: begin
               end
            endcase
         end
         if (state_ff == ST_EVAL) begin
            running_ff <= running_in;
            fault_ff <= fault_in;
            start_time_ff <= start_time_in;
            target_ff <= target_in;
            req_grams_ff <= req_grams_in;
            peak_ff <= peak_in;
            trip_ff <= trip_in;
            over_ff <= over_in;
            over_start_ff <= over_start_in;
         end
         if ((state_in == ST_DIV) && (state_ff != ST_DIV || tag_in != tag_ff)) begin
            div_go_ff <= 1'b1;
         end
         if (state_ff == ST_OUT && state_in == ST_IDLE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_bus.valid && req_bus.ready) begin
         mode_ff <= req_bus.mode;
         now_ff <= req_bus.now_ms;
         cur_ff <= req_bus.current_ma;
         batt_mv_ff <= req_bus.battery_mv;
         batt_valid_ff <= req_bus.battery_valid;
         sensor_ok_ff <= req_bus.sensor_ok;
         arg_ff <= req_bus.amount_or_duration;
      end
      if (state_ff == ST_PREP) begin
         div_num_ff <= DIV_W'(mass_prod) + DIV_W'(feed_rate_ff[31:1]);
         div_den_ff <= feed_rate_ff;
      end
      if (state_ff == ST_EVAL) begin
         res_ff <= res_in;
         fin_dur_ff <= elapsed;
         div_num_ff <= DIV_W'(elapsed) + DIV_W'(HALF_K);
         div_den_ff <= MS_PER_S;
      end
      if (state_ff == ST_FMUL) begin
         div_num_ff <= DIV_W'(mg_prod) + DIV_W'(HALF_K);
         div_den_ff <= MS_PER_S;
      end
      if (state_ff == ST_DIV && div_done) begin
         if (tag_ff == DT_MG) begin
            div_num_ff <= div_quo + DIV_W'(HALF_K);
         end else if (tag_ff == DT_G) begin
            res_ff.estimated_grams <= sat16(div_quo);
            div_num_ff <= DIV_W'(fin_dur_ff) + DIV_W'(HALF_K);
         end else if (tag_ff == DT_SEC) begin
            res_ff.duration_seconds <= sat16(div_quo);
         end
      end
      if (state_ff == ST_OUT && state_in == ST_IDLE) begin
         out_ff <= res_ff;
         motor_out_ff <= running_ff;
         fault_out_ff <= fault_ff;
         peak_out_ff <= peak_ff;
         trip_out_ff <= trip_ff;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.command_result = out_ff.command_result;
   assign rsp_bus.motor_on = motor_out_ff;
   assign rsp_bus.finish_kind = out_ff.finish_kind;
   assign rsp_bus.fault_code = fault_out_ff;
   assign rsp_bus.estimated_grams = out_ff.estimated_grams;
   assign rsp_bus.duration_seconds = out_ff.duration_seconds;
   assign rsp_bus.peak_current_ma = peak_out_ff;
   assign rsp_bus.trip_current_ma = trip_out_ff;
   assign rsp_bus.planned_grams = out_ff.planned_grams;

endmodule

// File: rtl/mrs_checker.sv
// Response-port checker for the motor run supervisor, with its bind.
`include "assert_macros.svh"

module mrs_checker
   import mrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  command_result,
   input logic        motor_on,
   input logic [1:0]  finish_kind,
   input logic [2:0]  fault_code,
   input logic [15:0] estimated_grams,
   input logic [15:0] duration_seconds,
   input logic [15:0] planned_grams
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `ASSERT_SAME(a_fin_motor_off, clock, reset, rsp_valid && finish_kind != FIN_NONE, !motor_on, "motor on after finish")
   `ASSERT_SAME(a_no_fin_zero, clock, reset, rsp_valid && finish_kind == FIN_NONE, estimated_grams == 16'd0 && duration_seconds == 16'd0 && planned_grams == 16'd0, "finish fields set without finish")
   `ASSERT_SAME(a_fin_cmd_ok, clock, reset, rsp_valid && finish_kind != FIN_NONE, command_result == RES_OK, "finish with failing command")
   `ASSERT_SAME(a_fault_code, clock, reset, rsp_valid && finish_kind == FIN_FAULT, fault_code != FLT_NONE, "fault finish without fault code")

endmodule

bind motor_run_supervisor mrs_checker u_mrs_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .command_result   (rsp_bus.command_result),
   .motor_on         (rsp_bus.motor_on),
   .finish_kind      (rsp_bus.finish_kind),
   .fault_code       (rsp_bus.fault_code),
   .estimated_grams  (rsp_bus.estimated_grams),
   .duration_seconds (rsp_bus.duration_seconds),
   .planned_grams    (rsp_bus.planned_grams)
);

// File: tb/sv/tb_motor_run_supervisor_channels.sv
// Channel interface instances are taken from the RTL; this file holds testbench-side types.
`timescale 1ns / 1ps
package tb_mrs_types;
   typedef struct packed {
      logic [2:0]  command_result;
      logic        motor_on;
      logic [1:0]  finish_kind;
      logic [2:0]  fault_code;
      logic [15:0] estimated_grams;
      logic [15:0] duration_seconds;
      logic [15:0] peak_current_ma;
      logic [15:0] trip_current_ma;
      logic [15:0] planned_grams;
   } run_report_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] now_ms;
      logic [15:0] current_ma;
      logic [15:0] battery_mv;
      logic        battery_valid;
      logic        sensor_ok;
      logic [31:0] amount_or_duration;
   } run_cmd_type;
endpackage

// File: tb/sv/tb_motor_run_supervisor.sv
// Self-checking testbench of the motor run supervisor: directed and random commands.
`timescale 1ns / 1ps
module tb_motor_run_supervisor;
   import mrs_pkg::*;
   import tb_mrs_types::*;

   class run_scoreboard;
      logic [31:0] feed_rate, max_run, cur_limit, cur_delay, crit_batt;
      logic        running, over_active;
      logic [2:0]  latched;
      logic [31:0] start_time, target, over_start;
      logic [15:0] req_grams, peak, trip;
      run_report_type pending[$];
      int          errors, checked, finishes, trips;

      function new();
         feed_rate = 32'd0; max_run = 32'd30000; cur_limit = 32'd2000; cur_delay = 32'd100;
         crit_batt = 32'd0;
         running = 1'b0; over_active = 1'b0; latched = FLT_NONE; start_time = 32'd0;
         target = 32'd0; over_start = 32'd0; req_grams = 16'd0; peak = 16'd0; trip = 16'd0;
         errors = 0; checked = 0; finishes = 0; trips = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            CSR_FEED_RATE: feed_rate = v;
            CSR_MAX_RUN:   max_run = v;
            CSR_CUR_LIMIT: cur_limit = {16'd0, v[15:0]};
            CSR_CUR_DELAY: cur_delay = v;
            CSR_CRIT_BATT: crit_batt = {16'd0, v[15:0]};
            default: ;
         endcase
      endfunction

      function bit batt_low(run_cmd_type c);
         return c.battery_valid && crit_batt != 32'd0 && {16'd0, c.battery_mv} < crit_batt;
      endfunction

      function void finish(ref run_report_type r, input logic [1:0] kind,
                           input logic [2:0] flt, input logic [31:0] now);
         logic [31:0] dur;
         logic [63:0] secs, mg, g;
         dur = now - start_time;
         secs = ({32'd0, dur} + 64'd500) / 64'd1000;
         r.finish_kind = kind;
         if (feed_rate == 32'd0) r.estimated_grams = 16'd0;
         else begin
            mg = ({32'd0, feed_rate} * {32'd0, dur} + 64'd500) / 64'd1000;
            g = (mg + 64'd500) / 64'd1000;
            r.estimated_grams = g > 64'd65535 ? 16'hFFFF : g[15:0];
         end
         r.duration_seconds = secs > 64'd65535 ? 16'hFFFF : secs[15:0];
         r.planned_grams = req_grams;
         latched = flt; running = 1'b0; req_grams = 16'd0; finishes++;
      endfunction

      function logic [2:0] begin_run(run_cmd_type c, logic [31:0] dur, logic [15:0] grams);
         if (running) return RES_BUSY;
         if (latched != FLT_NONE) return RES_FAULT;
         if (dur < 32'd100 || dur > max_run) return RES_RANGE;
         if (!c.sensor_ok) begin latched = FLT_SENSOR; return RES_SENSOR; end
         if (batt_low(c)) begin latched = FLT_BATTERY; return RES_BATTERY; end
         target = dur; req_grams = grams; peak = 16'd0; trip = 16'd0; over_active = 1'b0;
         start_time = c.now_ms; running = 1'b1;
         return RES_OK;
      endfunction

      function void note_command(run_cmd_type c);
         run_report_type r;
         logic [2:0]  res;
         logic [63:0] d;
         logic [31:0] el;
         bit          done;
         r = '0;
         res = RES_OK;
         done = 1'b0;
         case (c.mode)
            MODE_MASS: begin
               if (feed_rate == 32'd0) res = RES_UNCAL;
               else if (c.amount_or_duration < 32'd10 || c.amount_or_duration > 32'd65535)
                  res = RES_RANGE;
               else begin
                  d = ({32'd0, c.amount_or_duration} * 64'd1000000
                       + {32'd0, feed_rate >> 1}) / {32'd0, feed_rate};
                  if (d == 64'd0 || d > {32'd0, max_run}) res = RES_RANGE;
                  else res = begin_run(c, d[31:0], c.amount_or_duration[15:0]);
               end
            end
            MODE_TIMED: res = begin_run(c, c.amount_or_duration, 16'd0);
            MODE_STOP: begin
               if (!running) res = RES_NOT_RUN;
               else finish(r, FIN_USER, FLT_NONE, c.now_ms);
            end
            MODE_CLEAR: begin
               if (running) res = RES_BUSY;
               else if (!c.sensor_ok) begin latched = FLT_SENSOR; res = RES_SENSOR; end
               else if (batt_low(c)) res = RES_BATTERY;
               else latched = FLT_NONE;
            end
            MODE_TICK: if (running) begin
               if (c.current_ma > peak) peak = c.current_ma;
               if ({16'd0, c.current_ma} >= cur_limit) begin
                  if (!over_active) begin
                     over_active = 1'b1; over_start = c.now_ms;
                  end else if (c.now_ms - over_start >= cur_delay) begin
                     trip = c.current_ma; trips++;
                     finish(r, FIN_FAULT, FLT_OVERCURRENT, c.now_ms);
                     done = 1'b1;
                  end
               end else over_active = 1'b0;
               if (!done) begin
                  el = c.now_ms - start_time;
                  if (el >= max_run) finish(r, FIN_FAULT, FLT_MAXRUN, c.now_ms);
                  else if (batt_low(c) && el > 32'd1000)
                     finish(r, FIN_FAULT, FLT_BATTERY, c.now_ms);
                  else if (el >= target) finish(r, FIN_SUCCESS, FLT_NONE, c.now_ms);
               end
            end
            default: ;
         endcase
         r.command_result = res;
         r.motor_on = running;
         r.fault_code = latched;
         r.peak_current_ma = peak;
         r.trip_current_ma = trip;
         pending.push_back(r);
      endfunction

      function void check_report(run_report_type a);
         run_report_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %p", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, a);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #4 clock = ~clock;

   mrs_req_if req_bus();
   mrs_rsp_if rsp_bus();
   mrs_csr_if csr_bus();

   motor_run_supervisor dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   run_scoreboard sb = new();
   logic [31:0] now_ms = 32'd0;
   int          cycle = 0;
   int          hold_off = 0;
   bit          stall_phase = 1'b0;
   localparam int LIMIT = 3000000;

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("timeout at cycle %0d", cycle);
         $display("FAIL motor_run_supervisor");
         $finish;
      end
   end

   // response side: sample at rising edge, change ready at falling edge
   always @(posedge clock) begin
      run_report_type a;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         a.command_result = rsp_bus.command_result;
         a.motor_on = rsp_bus.motor_on;
         a.finish_kind = rsp_bus.finish_kind;
         a.fault_code = rsp_bus.fault_code;
         a.estimated_grams = rsp_bus.estimated_grams;
         a.duration_seconds = rsp_bus.duration_seconds;
         a.peak_current_ma = rsp_bus.peak_current_ma;
         a.trip_current_ma = rsp_bus.trip_current_ma;
         a.planned_grams = rsp_bus.planned_grams;
         sb.check_report(a);
      end
   end

   initial rsp_bus.ready = 1'b0;
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_bus.ready <= 1'b0;
      end else if (stall_phase) rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      else rsp_bus.ready <= 1'b1;
      if ($urandom_range(0, 199) == 0) stall_phase <= ~stall_phase;
   end

   task automatic send_cmd(run_cmd_type c);
      req_bus.valid <= 1'b1;
      req_bus.mode <= c.mode;
      req_bus.now_ms <= c.now_ms;
      req_bus.current_ma <= c.current_ma;
      req_bus.battery_mv <= c.battery_mv;
      req_bus.battery_valid <= c.battery_valid;
      req_bus.sensor_ok <= c.sensor_ok;
      req_bus.amount_or_duration <= c.amount_or_duration;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_command(c);
      @(negedge clock);
   endtask

   task automatic idle_req(int n);
      req_bus.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= v;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, v);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   function automatic run_cmd_type mk(logic [2:0] m, logic [31:0] arg,
                                      logic [15:0] cur = 16'd100);
      run_cmd_type c;
      c.mode = m; c.now_ms = now_ms; c.current_ma = cur;
      c.battery_mv = 16'd3700; c.battery_valid = 1'b1; c.sensor_ok = 1'b1;
      c.amount_or_duration = arg;
      return c;
   endfunction

   // a start followed by ticks with random content until the run ends or 40 ticks are sent, then a fault reset
   task automatic random_run();
      run_cmd_type c;
      int       k;
      c = mk($urandom_range(0, 3) == 0 ? MODE_TIMED : MODE_MASS,
             $urandom_range(0, 1) ? $urandom_range(10, 400) : $urandom_range(100, 3000));
      if ($urandom_range(0, 15) == 0) c.sensor_ok = 1'b0;
      if ($urandom_range(0, 15) == 0) c.battery_mv = 16'($urandom);
      send_cmd(c);
      for (k = 0; k < 40 && (sb.running || sb.pending.size() != 0); k++) begin
         now_ms = now_ms + $urandom_range(1, 120);
         c = mk(MODE_TICK, $urandom,
                $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2500)));
         c.battery_mv = $urandom_range(0, 5) == 0 ? 16'($urandom) : 16'd3700;
         c.battery_valid = 1'($urandom);
         c.sensor_ok = 1'($urandom);
         if ($urandom_range(0, 30) == 0) c.mode = MODE_STOP;
         else if ($urandom_range(0, 40) == 0) c.mode = 3'($urandom);
         send_cmd(c);
         if ($urandom_range(0, 5) == 0) idle_req($urandom_range(1, 12));
      end
      c = mk(MODE_CLEAR, $urandom);
      c.sensor_ok = $urandom_range(0, 7) != 0;
      send_cmd(c);
   endtask

   initial begin
      run_cmd_type c;
      int       sent, ph, n;
      req_bus.valid = 1'b0; req_bus.mode = MODE_TICK; req_bus.now_ms = 32'd0;
      req_bus.current_ma = 16'd0; req_bus.battery_mv = 16'd0; req_bus.battery_valid = 1'b0;
      req_bus.sensor_ok = 1'b0; req_bus.amount_or_duration = 32'd0;
      csr_bus.valid = 1'b0; csr_bus.index = CSR_FEED_RATE; csr_bus.data = 32'd0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed
      send_cmd(mk(MODE_MASS, 100));
      send_cmd(mk(MODE_STOP, 0));
      send_cmd(mk(MODE_TIMED, 99));
      send_cmd(mk(MODE_TIMED, 32'hFFFF_FFFF));
      send_cmd(mk(3'd5, 0)); send_cmd(mk(3'd6, 0)); send_cmd(mk(3'd7, 0));
      drain();
      write_csr(CSR_FEED_RATE, 32'd50000);
      write_csr(CSR_CRIT_BATT, 32'd3300);
      write_csr(CSR_CUR_DELAY, 32'd0);
      send_cmd(mk(MODE_MASS, 9));
      send_cmd(mk(MODE_MASS, 65536));
      send_cmd(mk(MODE_MASS, 65535));
      c = mk(MODE_TIMED, 500); c.battery_mv = 16'd3000; send_cmd(c);
      c = mk(MODE_CLEAR, 0); c.battery_mv = 16'd3000; send_cmd(c);
      send_cmd(mk(MODE_CLEAR, 0));
      c = mk(MODE_TIMED, 500); c.sensor_ok = 1'b0; send_cmd(c);
      send_cmd(mk(MODE_TIMED, 500));
      send_cmd(mk(MODE_CLEAR, 0));
      send_cmd(mk(MODE_MASS, 10));
      send_cmd(mk(MODE_CLEAR, 0));
      send_cmd(mk(MODE_STOP, 0));
      send_cmd(mk(MODE_TIMED, 30000));
      now_ms = now_ms + 5; send_cmd(mk(MODE_TICK, 0, 16'hFFFF));
      now_ms = now_ms + 1; send_cmd(mk(MODE_TICK, 0, 16'hFFFF));
      send_cmd(mk(MODE_CLEAR, 0));
      drain();

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_FEED_RATE, 32'hFFFF_FFFF); write_csr(CSR_MAX_RUN, 32'hFFFF_FFFF);
               write_csr(CSR_CUR_LIMIT, 32'h0000_FFFF); write_csr(CSR_CUR_DELAY, 32'hFFFF_FFFF);
               write_csr(CSR_CRIT_BATT, 32'h0000_FFFF);
            end
            1: begin
               write_csr(CSR_FEED_RATE, 32'd1); write_csr(CSR_MAX_RUN, 32'd0);
               write_csr(CSR_CUR_LIMIT, 32'd0); write_csr(CSR_CRIT_BATT, 32'd0);
            end
            default: begin
               write_csr(CSR_FEED_RATE, $urandom_range(2000, 200000));
               write_csr(CSR_MAX_RUN, $urandom_range(500, 6000));
               write_csr(CSR_CUR_LIMIT, $urandom_range(1500, 2400));
               write_csr(CSR_CUR_DELAY, $urandom_range(0, 300));
               write_csr(CSR_CRIT_BATT, $urandom_range(0, 1) ? 32'd3300 : 32'd0);
            end
         endcase
         if (ph == 3) hold_off = 400;
         sent = sb.checked + sb.pending.size();
         n = sent + 140;
         while (sb.checked + sb.pending.size() < n) begin
            if ($urandom_range(0, 4) == 0) begin
               c = mk(3'($urandom), $urandom, 16'($urandom));
               c.now_ms = $urandom; c.battery_mv = 16'($urandom);
               c.battery_valid = 1'($urandom); c.sensor_ok = 1'($urandom);
               send_cmd(c);
            end else random_run();
            if ($urandom_range(0, 2) == 0) idle_req($urandom_range(1, 20));
         end
         drain();
      end

      $display("checked %0d responses, %0d run finishes, %0d overcurrent trips",
               sb.checked, sb.finishes, sb.trips);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS motor_run_supervisor");
      else $display("FAIL motor_run_supervisor");
      $finish;
   end
endmodule
